@@ src/sliding_trimmed_mean_filter_macros.svh @@
// assertion macros shared by the trimmed mean filter rtl
// no dependencies; defining ASSERT_OFF turns every check into nothing
`ifndef SLIDING_TRIMMED_MEAN_FILTER_MACROS_SVH
`define SLIDING_TRIMMED_MEAN_FILTER_MACROS_SVH

`ifndef ASSERT_OFF

`define STMF_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("check failed");

`define STMF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

`define STMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`else

`define STMF_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define STMF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define STMF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/stmf_pkg.sv @@
// shared constants, fsm state type and controller/datapath structs
// no dependencies
package stmf_pkg;

    localparam int SAMPLE_W          = 8;
    localparam int CFG_W             = 4;
    localparam int MIN_WINDOW        = 3;
    localparam int WINDOW_DEPTH_DEF  = 8;
    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 4'd5;
    localparam int DIV_CNT_W         = $clog2(SAMPLE_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_DIVIDE,
        ST_EMIT
    } stmf_state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } stmf_cmd_t;

    typedef struct packed {
        logic fill_out;
        logic scan_last;
        logic div_last;
    } stmf_status_t;

endpackage

@@ src/stmf_ifs.sv @@
// valid/ready channel interfaces for sample, result and config words
// depends on stmf_pkg
interface stmf_sample_if;
    import stmf_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface stmf_filtered_if;
    import stmf_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

interface stmf_cfg_if;
    import stmf_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

@@ src/sliding_trimmed_mean_filter.sv @@
// top level of the sliding trimmed mean filter
// depends on stmf_pkg, stmf_ifs, stmf_ctrl and stmf_datapath
//
// usage:
//   samples: one 8-bit converter word per handshake (valid/ready)
//   results: one filtered word back for every sample word, in order
//   cfg:     window_size word, always ready, write only while idle
// while the window fills, the result is the sample itself, carried through
// the divider register and the emit step into the output register. once full,
// the block scans the n active entries for sum, min and max (one entry per
// cycle), drops min and max, and divides by n-2 with a restoring divider at
// one quotient bit per cycle before the emit step loads the output register.
// steps per full-window word: accept, scan, prep, divide and emit; while filling,
// only accept and emit. the scan loop and the serial divider set the time per word.
// the output register lets a new sample be accepted while the last result
// waits; if the receiver stalls, the next result holds in the emit step.
// reset: window length back to 5, fill count cleared, no result pending.
// window contents are not cleared; entries are written before being read.
module sliding_trimmed_mean_filter #(
    parameter int WINDOW_DEPTH = stmf_pkg::WINDOW_DEPTH_DEF
) (
    input logic      clk,
    input logic      rst_n,
    stmf_sample_if.sink     samples,
    stmf_filtered_if.source results,
    stmf_cfg_if.sink        cfg
);
    import stmf_pkg::*;

    stmf_cmd_t    cmd;
    stmf_status_t status;

    // config word is taken on any cycle
    assign cfg.ready = 1'b1;

    // sequencer: handshakes and step order
    stmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // window, scan accumulators, divider and output word
    stmf_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg.valid),
        .cfg_window_size (cfg.window_size),
        .sample          (samples.sample),
        .filtered        (results.filtered),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

@@ src/stmf_ctrl.sv @@
// sequencing state machine for the trimmed mean filter
// depends on stmf_pkg; drives the datapath through stmf_cmd_t
module stmf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  stmf_pkg::stmf_status_t status,
    output stmf_pkg::stmf_cmd_t    cmd
);
    import stmf_pkg::*;

    stmf_state_t state_reg;
    stmf_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.fill_out ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ src/stmf_datapath.sv @@
// window storage, min/max/sum scan, serial divider and output register
// depends on stmf_pkg and the assertion macro header
`include "sliding_trimmed_mean_filter_macros.svh"

module stmf_datapath #(
    parameter int WINDOW_DEPTH = stmf_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [stmf_pkg::CFG_W-1:0]    cfg_window_size,
    input  logic [stmf_pkg::SAMPLE_W-1:0] sample,
    output logic [stmf_pkg::SAMPLE_W-1:0] filtered,
    input  stmf_pkg::stmf_cmd_t           cmd,
    output stmf_pkg::stmf_status_t        status
);
    import stmf_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = $clog2(WINDOW_DEPTH * 255 + 1);
    localparam int REM_W = CNT_W + 1;

    logic [CFG_W-1:0]    window_size_reg;
    logic [CNT_W-1:0]    fill_count_reg;
    logic [SAMPLE_W-1:0] win_reg [WINDOW_DEPTH];
    logic [IDX_W-1:0]    idx_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] min_reg;
    logic [SAMPLE_W-1:0] max_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [SAMPLE_W-1:0] dvd_reg;
    logic [CNT_W-1:0]    divisor_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [SAMPLE_W-1:0] filtered_reg;

    logic [CNT_W-1:0]    eff_len;
    logic [IDX_W-1:0]    last_idx;
    logic                fill_lt;
    logic                full_now;
    logic [SAMPLE_W-1:0] rd;
    logic [SUM_W-1:0]    diff;
    logic [REM_W-1:0]    trial;
    logic                trial_ge;

    // window length saturated to the legal range
    always_comb
    begin
        priority if (int'(window_size_reg) < MIN_WINDOW)
        begin
            eff_len = CNT_W'(MIN_WINDOW);
        end
        else if (int'(window_size_reg) > WINDOW_DEPTH)
        begin
            eff_len = CNT_W'(WINDOW_DEPTH);
        end
        else
        begin
            eff_len = CNT_W'(window_size_reg);
        end
    end

    assign last_idx = IDX_W'(eff_len - CNT_W'(1));
    assign fill_lt  = fill_count_reg < eff_len;
    assign full_now = fill_lt ? ((fill_count_reg + CNT_W'(1)) >= eff_len) : 1'b1;
    assign rd       = win_reg[idx_reg];
    assign diff     = sum_reg - SUM_W'(min_reg) - SUM_W'(max_reg);
    assign trial    = {rem_reg[REM_W-2:0], dvd_reg[SAMPLE_W-1]};
    assign trial_ge = trial >= {1'b0, divisor_reg};

    assign status.fill_out  = !full_now;
    assign status.scan_last = idx_reg == last_idx;
    assign status.div_last  = div_cnt_reg == DIV_CNT_W'(SAMPLE_W - 1);
    assign filtered         = filtered_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
            fill_count_reg  <= '0;
            idx_reg         <= '0;
            div_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                window_size_reg <= cfg_window_size;
            end
            if (cmd.load && fill_lt)
            begin
                fill_count_reg <= fill_count_reg + CNT_W'(1);
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.div_init)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (fill_lt)
            begin
                win_reg[fill_count_reg[IDX_W-1:0]] <= sample;
            end
            else
            begin
                // slide the active part of the window by one
                for (int i = 0; i < WINDOW_DEPTH; i++)
                begin
                    if (i + 1 < int'(eff_len))
                    begin
                        win_reg[i] <= win_reg[i + 1];
                    end
                    else if (i + 1 == int'(eff_len))
                    begin
                        win_reg[i] <= sample;
                    end
                end
            end
            sum_reg <= '0;
            min_reg <= '1;
            max_reg <= '0;
            // sample passes straight through while filling
            dvd_reg <= sample;
        end
        if (cmd.scan_step)
        begin
            sum_reg <= sum_reg + SUM_W'(rd);
            if (rd < min_reg)
            begin
                min_reg <= rd;
            end
            if (rd > max_reg)
            begin
                max_reg <= rd;
            end
        end
        if (cmd.div_init)
        begin
            // quotient fits 8 bits, so the upper part is already below the divisor
            rem_reg     <= REM_W'(diff >> SAMPLE_W);
            dvd_reg     <= diff[SAMPLE_W-1:0];
            divisor_reg <= eff_len - CNT_W'(2);
        end
        else if (cmd.div_step)
        begin
            if (trial_ge)
            begin
                rem_reg <= trial - {1'b0, divisor_reg};
                dvd_reg <= {dvd_reg[SAMPLE_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                dvd_reg <= {dvd_reg[SAMPLE_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            filtered_reg <= dvd_reg;
        end
    end

    `STMF_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, int'(fill_count_reg) <= WINDOW_DEPTH)
    `STMF_ASSERT_IMPLIES(a_scan_in_window, clk, rst_n, cmd.scan_step, idx_reg <= last_idx)
    `STMF_ASSERT_NEXT(a_rem_below_div, clk, rst_n, cmd.div_init, rem_reg < REM_W'(divisor_reg))

endmodule

@@ bench/tb_sliding_trimmed_mean_filter.sv @@
`timescale 1ns / 100ps
// self-checking bench for sliding_trimmed_mean_filter: random and directed sample words
// depends on stmf_pkg, the stmf channel interfaces and the filter rtl in src
module tb_sliding_trimmed_mean_filter;
    import stmf_pkg::*;

    localparam int DEPTH        = WINDOW_DEPTH_DEF;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    // longest legal quiet stretch is the receiver hold-off plus a window's work
    localparam int HOLDOFF_CYCLES = 300;
    localparam int IDLE_LIMIT     = 2000;
    localparam int PHASE_WORDS    = 154;
    localparam int NUM_PHASES     = 8;
    localparam int MAX_PRINTS     = 60;

    logic clk;
    logic rst_n;

    stmf_sample_if   sample_ch ();
    stmf_filtered_if result_ch ();
    stmf_cfg_if      cfg_ch ();

    sliding_trimmed_mean_filter #(
        .WINDOW_DEPTH(DEPTH)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(sample_ch),
        .results(result_ch),
        .cfg    (cfg_ch)
    );

    // sample words waiting to go out, and filtered words owed by the block
    logic [7:0] pending_samples[$];
    logic [7:0] expected_means[$];

    // shadow of the filter state
    logic [7:0]       shadow_window[DEPTH];
    int unsigned      shadow_fill;
    logic [CFG_W-1:0] shadow_length;

    int mismatch_count;
    int idle_cycles;

    // traffic shaping knobs, set from the sequencer
    logic no_idle;
    logic sender_pause;
    logic holdoff_go;

    // sender and receiver private counters
    int burst_left;
    int gap_left;
    int holdoff_left;
    bit holdoff_armed;
    int stall_phase;
    logic [15:0] stall_mask;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("ERROR @%0t: %s", $realtime, what);
    endtask

    // advance the shadow window by one word and return the filtered word it owes
    function automatic logic [7:0] trimmed_mean_step(input logic [7:0] s);
        int unsigned n;
        int unsigned total;
        int i;
        logic [7:0] lo;
        logic [7:0] hi;
        // out-of-range lengths saturate to the legal span
        if (shadow_length < MIN_WINDOW)
            n = MIN_WINDOW;
        else if (shadow_length > DEPTH)
            n = DEPTH;
        else
            n = 32'(shadow_length);
        // a shrunk length makes an already longer fill count as full
        if (shadow_fill < n)
        begin
            shadow_window[shadow_fill] = s;
            shadow_fill++;
        end
        else
        begin
            for (i = 0; i + 1 < n; i++)
                shadow_window[i] = shadow_window[i + 1];
            shadow_window[n - 1] = s;
        end
        // still filling: the word passes straight through
        if (shadow_fill < n)
            return s;
        // dropping min and max is the same as trimming both ends of the sorted window
        total = 0;
        lo    = 8'hff;
        hi    = 8'h00;
        for (i = 0; i < n; i++)
        begin
            total += 32'(shadow_window[i]);
            if (shadow_window[i] < lo) lo = shadow_window[i];
            if (shadow_window[i] > hi) hi = shadow_window[i];
        end
        return 8'((total - 32'(lo) - 32'(hi)) / (n - 2));
    endfunction

    // sender: bursts of random length with random gaps, fed from pending_samples
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                expected_means.push_back(trimmed_mean_step(sample_ch.sample));
                void'(pending_samples.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            // a word not yet taken stays on the channel unchanged
            if (!(sample_ch.valid && !sample_ch.ready))
            begin
                if (gap_left > 0 && !no_idle)
                begin
                    gap_left--;
                    sample_ch.valid <= 1'b0;
                end
                else if (pending_samples.size() != 0 && !sender_pause)
                begin
                    gap_left = 0;
                    sample_ch.valid  <= 1'b1;
                    sample_ch.sample <= pending_samples[0];
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: random stall mask reloaded whenever the stall phase wraps to zero, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            holdoff_left  = 0;
            holdoff_armed = 1'b0;
            stall_phase   = 0;
            stall_mask    = '0;
        end
        else
        begin
            if (holdoff_go && !holdoff_armed)
            begin
                holdoff_armed = 1'b1;
                holdoff_left  = HOLDOFF_CYCLES;
            end
            else if (!holdoff_go)
                holdoff_armed = 1'b0;
            if (stall_phase == 0)
                stall_mask = no_idle ? 16'h0000 : 16'($urandom & $urandom);
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= !stall_mask[stall_phase];
            stall_phase = (stall_phase + 1) % 16;
        end
    end

    // monitor: every filtered word against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_means.size() == 0)
                report_mismatch($sformatf("filtered word %0d with nothing owed",
                                          result_ch.filtered));
            else
            begin
                if (result_ch.filtered !== expected_means[0])
                    report_mismatch($sformatf("filtered got %0d want %0d",
                                              result_ch.filtered, expected_means[0]));
                void'(expected_means.pop_front());
            end
        end
    end

    // watchdog: too long without any word moving on any channel
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // wait until nothing is queued, on the wire or owed
    task automatic wait_idle;
        while (pending_samples.size() != 0 || sample_ch.valid || expected_means.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // one config word; the shadow length follows at the accepting edge
    task automatic write_window_size(input logic [CFG_W-1:0] len);
        @(posedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.window_size <= len;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        shadow_length = len;
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // sequencer
    initial
    begin
        int p;
        int k;
        logic [7:0] level;
        logic [7:0] word;
        logic [CFG_W-1:0] len;

        rst_n              = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.window_size = '0;
        no_idle        = 1'b0;
        sender_pause   = 1'b0;
        holdoff_go     = 1'b0;
        mismatch_count = 0;
        shadow_fill    = 0;
        shadow_length  = WINDOW_SIZE_RESET;
        for (k = 0; k < DEPTH; k++)
            shadow_window[k] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset length: fill with extremes, the fifth word already averages
        pending_samples.push_back(8'd0);   pending_samples.push_back(8'd255);
        pending_samples.push_back(8'd1);   pending_samples.push_back(8'd254);
        pending_samples.push_back(8'd128); pending_samples.push_back(8'd255);
        pending_samples.push_back(8'd0);
        wait_idle();

        // zero saturates to three, a shrink on a full window; all-max window
        write_window_size(4'd0);
        pending_samples.push_back(8'd255); pending_samples.push_back(8'd255);
        pending_samples.push_back(8'd255); pending_samples.push_back(8'd0);
        wait_idle();

        // all ones saturates to the depth; fill resumes where it stopped
        write_window_size(4'd15);
        pending_samples.push_back(8'd200); pending_samples.push_back(8'd10);
        pending_samples.push_back(8'd99);  pending_samples.push_back(8'd255);
        pending_samples.push_back(8'd255);
        wait_idle();

        write_window_size(4'd3);
        pending_samples.push_back(8'd7); pending_samples.push_back(8'd170);
        wait_idle();

        write_window_size(4'd8);
        pending_samples.push_back(8'd85); pending_samples.push_back(8'd1);
        wait_idle();

        // random phases, each under its own length and traffic shape
        level = 8'd128;
        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       len = 4'd8;
                1:       len = 4'd3;
                2:       len = 4'd0;
                3:       len = 4'd15;
                4:       len = 4'd5;
                default: len = 4'($urandom_range(0, 15));
            endcase
            write_window_size(len);
            no_idle <= (p == 4);
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                // mostly a noisy slow signal, with impulses and plain noise mixed in
                case ($urandom_range(0, 9))
                    0, 1:    word = 8'($urandom_range(0, 255));
                    2:       word = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    default:
                    begin
                        level = 8'(int'(level) + $urandom_range(0, 6) - 3);
                        word  = 8'(int'(level) + $urandom_range(0, 10) - 5);
                    end
                endcase
                pending_samples.push_back(word);
            end
            // receiver holds off long enough for the input to back up
            if (p == 1)
                holdoff_go <= 1'b1;
            // sender stops mid-phase until every owed word is back
            if (p == 3)
            begin
                while (pending_samples.size() > PHASE_WORDS / 2)
                    @(negedge clk);
                sender_pause <= 1'b1;
                @(negedge clk);
                while (sample_ch.valid || expected_means.size() != 0)
                    @(negedge clk);
                sender_pause <= 1'b0;
            end
            wait_idle();
            holdoff_go <= 1'b0;
        end

        repeat (40) @(negedge clk);
        if (expected_means.size() != 0)
            report_mismatch($sformatf("%0d filtered words never came",
                                      expected_means.size()));
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/stmf_pkg.sv
src/stmf_ifs.sv
src/stmf_ctrl.sv
src/stmf_datapath.sv
src/sliding_trimmed_mean_filter.sv
bench/tb_sliding_trimmed_mean_filter.sv
